// File: src/tcprc_pkg.sv
// Shared types, constants and codes for the Reno window controller.
// Used by the divider, datapath, controller and top level; depends on nothing.
package tcprc_pkg;

    localparam int SEQ_W     = 16;              // segment, window and threshold width
    localparam int ACK_W     = 17;              // acknowledged segment number width
    localparam int LS_W      = 18;              // last sent, signed so that it can hold minus one
    localparam int FRAC_W    = 32;              // Q16.16 window
    localparam int FRAC_FB   = 16;              // fraction bits of the Q16.16 window
    localparam int QUO_W     = 34;              // quotient of 2^32 by a 32 bit divisor, even width
    localparam int DIV_STEPS = QUO_W / 2;       // two quotient bits per cycle
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [SEQ_W-1:0]  TOTAL_RESET   = 16'd50;
    localparam logic [SEQ_W-1:0]  THRESH_RESET  = 16'd10;
    localparam logic [SEQ_W-1:0]  WIN_MAX       = 16'hFFFF;
    localparam logic [ACK_W-1:0]  ACK_MAX       = 17'h1_0000;
    localparam logic [1:0]        DUP_ACK_LIMIT = 2'd3;
    localparam logic [FRAC_W-1:0] Q_ONE         = 32'h0001_0000;
    localparam logic [QUO_W-1:0]  DIVIDEND      = 34'h1_0000_0000;

    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_ACK     = 2'd1,
        CMD_TIMEOUT = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        PH_SS = 2'd0,
        PH_CA = 2'd1,
        PH_FR = 2'd2
    } t_phase;

    typedef enum logic {
        REG_TOTAL       = 1'b0,
        REG_INIT_THRESH = 1'b1
    } t_reg_idx;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_RELOAD,
        OP_TIMEOUT,
        OP_DUP_FR,
        OP_DUP_INC,
        OP_DUP_ENTER,
        OP_NEW_SS,
        OP_NEW_FR,
        OP_NEW_CA,
        OP_CA_APPLY,
        OP_BURST,
        OP_BURST_SS,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_DIV,
        S_APPLY,
        S_BURST,
        S_BURST_SS,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0] cmd;
        logic       done;
        logic       is_dup;
        t_phase     phase;
        logic       dup_hit;
        logic       div_busy;
    } t_dp_status;

endpackage

// File: src/tcprc_div.sv
// Iterative restoring divider: floor(2^32 / divisor), two quotient bits a cycle.
// Depends on tcprc_pkg.
module tcprc_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [tcprc_pkg::FRAC_W-1:0]   i_divisor,
    output logic                           o_busy,
    output logic [tcprc_pkg::QUO_W-1:0]    o_quot
);
    import tcprc_pkg::*;

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [FRAC_W-1:0]    r_div;
    logic [FRAC_W-1:0]    r_rem;
    logic [QUO_W-1:0]     r_quo;

    logic [FRAC_W:0]      sh1, sh2;
    logic [FRAC_W-1:0]    rem1, rem2;
    logic                 q1, q2;
    logic [QUO_W-1:0]     n_quo;

    // two compare-and-subtract steps per cycle
    always_comb begin
        sh1   = {r_rem, r_quo[QUO_W-1]};
        q1    = (sh1 >= {1'b0, r_div});
        rem1  = q1 ? FRAC_W'(sh1 - {1'b0, r_div}) : sh1[FRAC_W-1:0];
        sh2   = {rem1, r_quo[QUO_W-2]};
        q2    = (sh2 >= {1'b0, r_div});
        rem2  = q2 ? FRAC_W'(sh2 - {1'b0, r_div}) : sh2[FRAC_W-1:0];
        n_quo = {r_quo[QUO_W-3:0], q1, q2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= DIVIDEND;
            // a zero window divides as one
            r_div <= (i_divisor == '0) ? FRAC_W'(1) : i_divisor;
        end else if (r_busy) begin
            r_rem <= rem2;
            r_quo <= n_quo;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quo;

endmodule

// File: src/tcprc_dp.sv
// Datapath: window state, configuration registers, burst arithmetic and result register.
// Depends on tcprc_pkg and tcprc_div; steered by t_op commands from tcprc_ctrl.
module tcprc_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tcprc_pkg::t_op                i_op,
    input  logic [1:0]                    i_cmd,
    input  logic [tcprc_pkg::ACK_W-1:0]   i_ack_number,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [tcprc_pkg::SEQ_W-1:0]   i_cfg_data,
    output tcprc_pkg::t_dp_status         o_status,
    output logic [tcprc_pkg::SEQ_W-1:0]   o_burst_first,
    output logic [tcprc_pkg::SEQ_W-1:0]   o_burst_count,
    output logic [tcprc_pkg::SEQ_W-1:0]   o_window,
    output logic [tcprc_pkg::SEQ_W-1:0]   o_threshold,
    output logic [1:0]                    o_phase,
    output logic                          o_done_res
);
    import tcprc_pkg::*;

    // configuration
    logic [SEQ_W-1:0] r_total, r_init_thr;
    // latched word
    logic [1:0]       r_cmd;
    logic [ACK_W-1:0] r_ack;
    // window state
    t_phase                  r_phase, n_phase;
    logic [SEQ_W-1:0]        r_cwnd, n_cwnd;
    logic [FRAC_W-1:0]       r_frac, n_frac;
    logic [SEQ_W-1:0]        r_thr, n_thr;
    logic [1:0]              r_dup, n_dup;
    logic signed [LS_W-1:0]  r_last_sent, n_last_sent;
    logic [ACK_W-1:0]        r_last_acked, n_last_acked;
    // burst of the current word
    logic [SEQ_W-1:0]        r_first, n_first, r_count, n_count;
    // result register
    logic [SEQ_W-1:0]        r_o_first, r_o_count, r_o_win, r_o_thr;
    logic [1:0]              r_o_phase;
    logic                    r_o_done;

    logic [ACK_W-1:0]        ack_clamp;
    logic [SEQ_W-1:0]        cwnd_inc, half, fr_win, thr_or_one;
    logic [SEQ_W:0]          fr_sum;
    logic [QUO_W:0]          ca_sum;
    logic [FRAC_W-1:0]       ca_frac;
    logic signed [LS_W-1:0]  total_s, avail, cwnd_ext, n_send, ls_from_acked;
    logic                    can_send, send;
    logic                    done_now;
    logic                    div_busy;
    logic [QUO_W-1:0]        quot;

    tcprc_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_op == OP_NEW_CA),
        .i_divisor (r_frac),
        .o_busy    (div_busy),
        .o_quot    (quot)
    );

    // arithmetic shared by the commands
    always_comb begin
        ack_clamp     = (i_ack_number > ACK_MAX) ? ACK_MAX : i_ack_number;
        cwnd_inc      = (r_cwnd == WIN_MAX) ? WIN_MAX : r_cwnd + 1'b1;
        half          = {1'b0, r_cwnd[SEQ_W-1:1]};
        fr_sum        = {1'b0, half} + (SEQ_W + 1)'(DUP_ACK_LIMIT);
        fr_win        = fr_sum[SEQ_W] ? WIN_MAX : fr_sum[SEQ_W-1:0];
        thr_or_one    = (r_thr == '0) ? SEQ_W'(1) : r_thr;
        ca_sum        = {3'b000, r_frac} + {1'b0, quot};
        ca_frac       = (ca_sum[QUO_W:FRAC_W] != '0) ? '1 : ca_sum[FRAC_W-1:0];
        ls_from_acked = $signed({1'b0, r_last_acked}) - LS_W'(1);
        // burst: up to the window, never past total
        total_s       = $signed({2'b00, r_total});
        cwnd_ext      = $signed({2'b00, r_cwnd});
        can_send      = (r_last_sent < total_s);
        avail         = total_s - r_last_sent;
        n_send        = (cwnd_ext < avail) ? cwnd_ext : avail;
        send          = can_send && (n_send != '0);
        done_now      = (r_last_acked > {1'b0, r_total});
    end

    always_comb begin
        n_phase      = r_phase;
        n_cwnd       = r_cwnd;
        n_frac       = r_frac;
        n_thr        = r_thr;
        n_dup        = r_dup;
        n_last_sent  = r_last_sent;
        n_last_acked = r_last_acked;
        n_first      = r_first;
        n_count      = r_count;
        unique case (i_op)
            OP_LOAD: begin
                n_first = '0;
                n_count = '0;
            end
            OP_RELOAD: begin
                n_phase      = PH_SS;
                n_cwnd       = SEQ_W'(1);
                n_frac       = Q_ONE;
                n_thr        = r_init_thr;
                n_dup        = '0;
                n_last_sent  = -LS_W'(1);
                n_last_acked = '0;
            end
            OP_TIMEOUT: begin
                n_thr       = half;
                n_cwnd      = SEQ_W'(1);
                n_dup       = '0;
                n_phase     = PH_SS;
                n_last_sent = ls_from_acked;
            end
            OP_DUP_FR: begin
                n_cwnd = cwnd_inc;
            end
            OP_DUP_INC: begin
                n_dup = r_dup + 1'b1;
            end
            OP_DUP_ENTER: begin
                n_dup       = r_dup + 1'b1;
                n_thr       = half;
                n_cwnd      = fr_win;
                n_phase     = PH_FR;
                n_last_sent = ls_from_acked;
            end
            OP_NEW_SS: begin
                n_last_acked = r_ack;
                n_dup        = '0;
                n_cwnd       = cwnd_inc;
            end
            OP_NEW_FR: begin
                n_last_acked = r_ack;
                n_dup        = '0;
                n_cwnd       = thr_or_one;
                n_phase      = PH_CA;
                n_frac       = {thr_or_one, FRAC_FB'(0)};
            end
            OP_NEW_CA: begin
                n_last_acked = r_ack;
                n_dup        = '0;
            end
            OP_CA_APPLY: begin
                n_frac = ca_frac;
                n_cwnd = ca_frac[FRAC_W-1:FRAC_FB];
            end
            OP_BURST, OP_BURST_SS: begin
                if (send) begin
                    n_first     = SEQ_W'(r_last_sent + LS_W'(1));
                    n_count     = n_send[SEQ_W-1:0];
                    n_last_sent = r_last_sent + n_send;
                end
                // slow start hands over once the window reaches the threshold
                if (i_op == OP_BURST_SS && r_cwnd >= r_thr) begin
                    n_phase = PH_CA;
                    n_frac  = {r_cwnd, FRAC_FB'(0)};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total      <= TOTAL_RESET;
            r_init_thr   <= THRESH_RESET;
            r_phase      <= PH_SS;
            r_cwnd       <= SEQ_W'(1);
            r_frac       <= Q_ONE;
            r_thr        <= THRESH_RESET;
            r_dup        <= '0;
            r_last_sent  <= -LS_W'(1);
            r_last_acked <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_TOTAL) begin
                    r_total <= i_cfg_data;
                end else begin
                    r_init_thr <= i_cfg_data;
                end
            end
            r_phase      <= n_phase;
            r_cwnd       <= n_cwnd;
            r_frac       <= n_frac;
            r_thr        <= n_thr;
            r_dup        <= n_dup;
            r_last_sent  <= n_last_sent;
            r_last_acked <= n_last_acked;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first <= n_first;
        r_count <= n_count;
        if (i_op == OP_LOAD) begin
            r_cmd <= i_cmd;
            r_ack <= ack_clamp;
        end
        if (i_op == OP_EMIT) begin
            r_o_first <= r_first;
            r_o_count <= r_count;
            r_o_win   <= r_cwnd;
            r_o_thr   <= r_thr;
            r_o_phase <= r_phase;
            r_o_done  <= done_now;
        end
    end

    always_comb begin
        o_status.cmd      = r_cmd;
        o_status.done     = done_now;
        o_status.is_dup   = (r_ack == r_last_acked);
        o_status.phase    = r_phase;
        o_status.dup_hit  = ((r_dup + 1'b1) == DUP_ACK_LIMIT);
        o_status.div_busy = div_busy;
    end

    assign o_burst_first = r_o_first;
    assign o_burst_count = r_o_count;
    assign o_window      = r_o_win;
    assign o_threshold   = r_o_thr;
    assign o_phase       = r_o_phase;
    assign o_done_res    = r_o_done;

endmodule

// File: src/tcprc_ctrl.sv
// Controller: sequences one word through decide, divide, burst and result stages.
// Depends on tcprc_pkg; drives t_op commands into tcprc_dp.
module tcprc_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_out_stall,
    input  tcprc_pkg::t_dp_status  i_status,
    output tcprc_pkg::t_op         o_op,
    output logic                   o_in_stall,
    output logic                   o_out_valid
);
    import tcprc_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_op    dec_op;
    t_state dec_next;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    // event decode on the latched word and the state before the event
    always_comb begin
        dec_op   = OP_NONE;
        dec_next = S_EMIT;
        if (i_status.cmd == CMD_START) begin
            dec_op   = OP_RELOAD;
            dec_next = S_BURST;
        end else if (!i_status.done && i_status.cmd == CMD_TIMEOUT) begin
            dec_op   = OP_TIMEOUT;
            dec_next = S_BURST;
        end else if (!i_status.done && i_status.cmd == CMD_ACK) begin
            if (i_status.is_dup) begin
                priority if (i_status.phase == PH_FR) begin
                    dec_op   = OP_DUP_FR;
                    dec_next = S_BURST;
                end else if (i_status.dup_hit) begin
                    dec_op   = OP_DUP_ENTER;
                    dec_next = S_BURST;
                end else begin
                    dec_op   = OP_DUP_INC;
                    dec_next = S_EMIT;
                end
            end else begin
                unique case (i_status.phase)
                    PH_CA: begin
                        dec_op   = OP_NEW_CA;
                        dec_next = S_DIV;
                    end
                    PH_FR: begin
                        dec_op   = OP_NEW_FR;
                        dec_next = S_EMIT;
                    end
                    default: begin
                        dec_op   = OP_NEW_SS;
                        dec_next = S_BURST_SS;
                    end
                endcase
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_in_valid) n_state = S_DECIDE;
            S_DECIDE:   n_state = dec_next;
            S_DIV:      if (!i_status.div_busy) n_state = S_APPLY;
            S_APPLY:    n_state = S_BURST;
            S_BURST:    n_state = S_EMIT;
            S_BURST_SS: n_state = S_EMIT;
            S_EMIT:     if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_op = OP_NONE;
        unique case (r_state)
            S_IDLE:     if (i_in_valid) o_op = OP_LOAD;
            S_DECIDE:   o_op = dec_op;
            S_DIV:      o_op = OP_NONE;
            S_APPLY:    o_op = OP_CA_APPLY;
            S_BURST:    o_op = OP_BURST;
            S_BURST_SS: o_op = OP_BURST_SS;
            S_EMIT:     if (out_free) o_op = OP_EMIT;
            default:    o_op = OP_NONE;
        endcase
        n_out_valid = r_out_valid;
        if (o_op == OP_EMIT) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: src/tcp_reno_congestion_control_top.sv
// Top level of the Reno sender window controller.
// Depends on tcprc_pkg, tcprc_ctrl, tcprc_dp (which holds tcprc_div).
// Input: i_in_valid / o_in_stall carry one event word (i_cmd, i_ack_number), taken at
//   an edge with valid high and stall low. Start reloads the window state and sends the
//   first burst, ACK advances it, timeout restarts from the last acknowledged segment.
// Output: o_out_valid / i_out_stall carry one result word per event: the burst (first
//   segment, count), window, threshold, phase and done flag.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index (0 total segments,
//   1 initial threshold); write only while the block is idle.
// Timing: one event at a time. After acceptance the word passes a decide step and, for an
//   event that may send a burst, a burst step before the result register loads; one that
//   sends none loads it straight after decide. A new ACK in congestion avoidance first waits
//   on the reciprocal divider (two quotient bits a cycle) feeding the Q16.16 window, then
//   an apply step and the burst step. The next word is taken in the cycle after the load.
// Stall: o_in_stall is high from the cycle after acceptance until the result is loaded.
//   While the receiver stalls, the result register holds its word and the next event is
//   still accepted and worked; only its result load waits for the register to free.
// Reset: synchronous, active low: window 1, threshold 10, total segments 50, slow start,
//   nothing sent yet; no result pending.
module tcp_reno_congestion_control_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_cmd,
    input  logic [tcprc_pkg::ACK_W-1:0]   i_ack_number,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tcprc_pkg::SEQ_W-1:0]   o_burst_first,
    output logic [tcprc_pkg::SEQ_W-1:0]   o_burst_count,
    output logic [tcprc_pkg::SEQ_W-1:0]   o_window,
    output logic [tcprc_pkg::SEQ_W-1:0]   o_threshold,
    output logic [1:0]                    o_phase,
    output logic                          o_done_res,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [tcprc_pkg::SEQ_W-1:0]   i_cfg_data
);
    import tcprc_pkg::*;

    t_op        op;
    t_dp_status status;

    // sequence each word: decode, optional divide and burst, result load
    tcprc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_op        (op),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // hold the window state and the result register
    tcprc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (op),
        .i_cmd         (i_cmd),
        .i_ack_number  (i_ack_number),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_status      (status),
        .o_burst_first (o_burst_first),
        .o_burst_count (o_burst_count),
        .o_window      (o_window),
        .o_threshold   (o_threshold),
        .o_phase       (o_phase),
        .o_done_res    (o_done_res)
    );

    // one event at a time: a taken word closes the input until its result is loaded
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted twice in a row");

    // an empty burst reports segment zero
    a_empty_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_burst_count == '0) |-> (o_burst_first == '0))
        else $error("empty burst with nonzero first segment");

    // a burst never exceeds the window, and the window never drops to zero
    a_burst_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_burst_count <= o_window && o_window != '0))
        else $error("burst larger than window or zero window");

    // the divider runs only while the controller waits on it
    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.div_busy |-> o_in_stall)
        else $error("divider busy while idle");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for tcp_reno_congestion_control_top: event words in, window words out.
// Depends on tcprc_pkg and the RTL under src; holds its own window predictor and result queue.
module testbench;
    import tcprc_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;   // command code the block must ignore
    localparam int         SETTLE_CYC  = 30;     // covers the avoidance path through the divider
    localparam int         HOLD_CYC    = 300;    // long receiver hold-off for the pressure test

    // Expected result word, one per accepted event word
    typedef struct packed {
        logic [SEQ_W-1:0] first;
        logic [SEQ_W-1:0] count;
        logic [SEQ_W-1:0] window;
        logic [SEQ_W-1:0] thresh;
        t_phase           phase;
        logic             done;
    } t_window_result;

    // Block inputs, all known from time zero
    logic               i_clk;
    logic               i_rst_n      = 1'b0;
    logic               i_in_valid   = 1'b0;
    logic [1:0]         i_cmd        = CMD_START;
    logic [ACK_W-1:0]   i_ack_number = '0;
    logic               i_out_stall  = 1'b0;
    logic               i_cfg_we     = 1'b0;
    logic               i_cfg_index  = REG_TOTAL;
    logic [SEQ_W-1:0]   i_cfg_data   = '0;

    // Block outputs
    logic               o_in_stall;
    logic               o_out_valid;
    logic [SEQ_W-1:0]   o_burst_first;
    logic [SEQ_W-1:0]   o_burst_count;
    logic [SEQ_W-1:0]   o_window;
    logic [SEQ_W-1:0]   o_threshold;
    logic [1:0]         o_phase;
    logic               o_done_res;

    // Predictor state: configuration mirror and window controller state
    logic [SEQ_W-1:0]   cfg_total;
    logic [SEQ_W-1:0]   cfg_thresh_init;
    t_phase             st_phase;
    logic [SEQ_W-1:0]   st_win;
    logic [FRAC_W-1:0]  st_frac;
    logic [SEQ_W-1:0]   st_thresh;
    logic [1:0]         st_dups;
    int                 st_sent;
    int                 st_acked;

    t_window_result     pending_results[$];
    int                 error_count = 0;

    // Stimulus-side bookkeeping
    int                 burst_left    = 0;
    bit                 sender_eager  = 1'b0;
    bit                 hold_request  = 1'b0;
    int                 flow_total    = 50;
    int                 flow_acked    = 0;

    tcp_reno_congestion_control_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_ack_number  (i_ack_number),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_burst_first (o_burst_first),
        .o_burst_count (o_burst_count),
        .o_window      (o_window),
        .o_threshold   (o_threshold),
        .o_phase       (o_phase),
        .o_done_res    (o_done_res),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Window predictor
    // ------------------------------------------------------------------

    // Clamp a window sum at the 16-bit ceiling
    function automatic logic [SEQ_W-1:0] sat_window(input int v);
        return (v > int'(WIN_MAX)) ? WIN_MAX : 16'(v);
    endfunction

    // Reload the window state as a start event does
    function automatic void reload_window();
        st_phase  = PH_SS;
        st_win    = 16'd1;
        st_frac   = Q_ONE;
        st_thresh = cfg_thresh_init;
        st_dups   = 2'd0;
        st_sent   = -1;
        st_acked  = 0;
    endfunction

    // Take the next run of segments: at most a window of them, never past the last segment
    function automatic void take_burst(output logic [SEQ_W-1:0] first,
                                       output logic [SEQ_W-1:0] count);
        int n;
        first = '0;
        count = '0;
        if (st_sent >= int'(cfg_total))
            return;
        n = int'(cfg_total) - st_sent;
        if (n > int'(st_win))
            n = int'(st_win);
        if (n > 0) begin
            first   = 16'(st_sent + 1);
            count   = 16'(n);
            st_sent = st_sent + n;
        end
    endfunction

    function automatic void enter_avoidance();
        st_phase = PH_CA;
        st_frac  = {st_win, 16'h0000};
    endfunction

    // Advance the predictor by one event word and return the result word it should give
    function automatic t_window_result predict_event(input logic [1:0]       cmd,
                                                     input logic [ACK_W-1:0] raw_ack);
        t_window_result  r;
        int              ack;
        bit              finished;
        logic [31:0]     divisor;
        longint unsigned sum;
        r        = '0;
        ack      = (raw_ack > ACK_MAX) ? int'(ACK_MAX) : int'(raw_ack);
        finished = (st_acked > int'(cfg_total));
        case (cmd)
            CMD_START: begin
                reload_window();
                take_burst(r.first, r.count);
            end
            CMD_TIMEOUT: begin
                if (!finished) begin
                    st_thresh = st_win >> 1;
                    st_win    = 16'd1;
                    st_dups   = 2'd0;
                    st_phase  = PH_SS;
                    st_sent   = st_acked - 1;
                    take_burst(r.first, r.count);
                end
            end
            CMD_ACK: begin
                if (!finished && ack == st_acked) begin
                    if (st_phase == PH_FR) begin
                        // inflate the window for every further duplicate
                        st_win = sat_window(int'(st_win) + 1);
                        take_burst(r.first, r.count);
                    end else begin
                        st_dups = st_dups + 2'd1;
                        if (st_dups == DUP_ACK_LIMIT) begin
                            // third duplicate: halve, inflate, resend from the hole
                            st_thresh = st_win >> 1;
                            st_win    = sat_window(int'(st_thresh) + int'(DUP_ACK_LIMIT));
                            st_phase  = PH_FR;
                            st_sent   = ack - 1;
                            take_burst(r.first, r.count);
                        end
                    end
                end else if (!finished) begin
                    // new ACK, an older number counts as new too
                    st_acked = ack;
                    st_dups  = 2'd0;
                    if (st_phase == PH_CA) begin
                        divisor = (st_frac != '0) ? st_frac : 32'd1;
                        sum     = longint'(st_frac) + ((64'd1 << 32) / divisor);
                        if (sum > 64'hFFFF_FFFF)
                            sum = 64'hFFFF_FFFF;
                        st_frac = sum[31:0];
                        st_win  = st_frac[31:16];
                        take_burst(r.first, r.count);
                    end else if (st_phase == PH_FR) begin
                        // deflate to the threshold, no burst
                        st_win = (st_thresh != '0) ? st_thresh : 16'd1;
                        enter_avoidance();
                    end else begin
                        st_win = sat_window(int'(st_win) + 1);
                        take_burst(r.first, r.count);
                        if (st_win >= st_thresh)
                            enter_avoidance();
                    end
                end
            end
            default: ;
        endcase
        r.window = st_win;
        r.thresh = st_thresh;
        r.phase  = st_phase;
        r.done   = (st_acked > int'(cfg_total));
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: sample at the clock edge, predict on input words, check output words
    // ------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_window_result want;
        if (!i_rst_n) begin
            cfg_total       = TOTAL_RESET;
            cfg_thresh_init = THRESH_RESET;
            reload_window();
            pending_results.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_TOTAL)
                    cfg_total = i_cfg_data;
                else
                    cfg_thresh_init = i_cfg_data;
            end
            // check before queuing: a word cannot come out on the edge it went in
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    error_count++;
                    $display("%0t: result word with none expected, expected none, actual %0d/%0d",
                             $time, o_burst_first, o_burst_count);
                end else begin
                    want = pending_results.pop_front();
                    check_field("burst_first", want.first,  o_burst_first);
                    check_field("burst_count", want.count,  o_burst_count);
                    check_field("window",      want.window, o_window);
                    check_field("threshold",   want.thresh, o_threshold);
                    check_field("phase",       want.phase,  o_phase);
                    check_field("done_res",    want.done,   o_done_res);
                end
            end
            if (i_in_valid && !o_in_stall)
                pending_results.push_back(predict_event(i_cmd, i_ack_number));
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall in runs of random density; on request hold off for a long stretch
    // ------------------------------------------------------------------

    initial begin : receiver
        int hold_left;
        int run_left;
        int stall_pct;
        hold_left = 0;
        run_left  = 0;
        stall_pct = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYC;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    run_left = $urandom_range(10, 80);
                    case ($urandom_range(0, 4))
                        0, 1:    stall_pct = 0;     // stretches with no stall at all
                        2:       stall_pct = 30;
                        3:       stall_pct = 60;
                        default: stall_pct = 90;
                    endcase
                end
                run_left--;
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------

    // Offer one event word; return at the edge that accepts it with valid still high
    task automatic send_event(input logic [1:0] cmd, input logic [ACK_W-1:0] ack);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 10);
        end
        if (sender_eager)
            gap = 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_ack_number <= ack;
        do
            @(posedge i_clk);
        while (o_in_stall);
    endtask

    // Drop valid, wait for every expected word, then let the block go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_results.size() != 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Write both registers back to back while the block is idle
    task automatic write_config(input logic [SEQ_W-1:0] total, input logic [SEQ_W-1:0] thresh);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_TOTAL;
        i_cfg_data  <= total;
        @(posedge i_clk);
        i_cfg_index <= REG_INIT_THRESH;
        i_cfg_data  <= thresh;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        flow_total  = int'(total);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values, every event kind, fast recovery entry and exit, clamping, done handling
    task automatic test_directed();
        send_event(CMD_START,   17'd0);
        send_event(CMD_ACK,     17'd1);          // slow start growth
        send_event(CMD_ACK,     17'd3);
        repeat (3) send_event(CMD_ACK, 17'd3);  // third duplicate enters fast recovery
        send_event(CMD_ACK,     17'd3);          // duplicate inside fast recovery
        send_event(CMD_ACK,     17'd6);          // new ACK leaves fast recovery
        send_event(CMD_ACK,     17'd8);          // reciprocal step in avoidance
        send_event(CMD_ACK,     17'd10);
        send_event(CMD_TIMEOUT, 17'h1_FFFF);
        send_event(CMD_ACK,     17'd9);          // older number counts as new
        send_event(CMD_ACK,     17'h1_FFFF);     // out of range, clamps and finishes
        send_event(CMD_ACK,     17'd5);          // ignored once done
        send_event(CMD_TIMEOUT, 17'd0);
        send_event(CMD_UNUSED,  17'h1_5555);
        send_event(CMD_START,   17'h1_FFFF);
        send_event(CMD_ACK,     17'd0);          // duplicate of the start position
        send_event(CMD_ACK,     17'h1_0000);     // largest legal number
    endtask

    // Register extremes: nothing but segment 0, and the widest transfer
    task automatic test_config_extremes();
        write_config(16'd0, 16'd0);
        send_event(CMD_START,   17'd0);          // only segment 0 goes out
        send_event(CMD_ACK,     17'd0);
        send_event(CMD_TIMEOUT, 17'd0);
        send_event(CMD_ACK,     17'd1);          // past the last segment
        write_config(WIN_MAX, WIN_MAX);
        send_event(CMD_START,   17'd0);
        send_event(CMD_ACK,     17'd1);
        send_event(CMD_ACK,     17'h0_FFFF);
        send_event(CMD_ACK,     17'h1_0000);
    endtask

    // Fill the block against a long receiver hold-off, then pause until all words are back
    task automatic test_backpressure();
        write_config(16'd200, 16'd8);
        sender_eager = 1'b1;
        send_event(CMD_START, 17'd0);
        hold_request = 1'b1;
        for (int n = 1; n <= 30; n++)
            send_event(CMD_ACK, (n % 7 == 0) ? 17'(n - 1) : 17'(n));
        sender_eager = 1'b0;
        settle();
    endtask

    // Mostly well-formed transfers with random content, some noise and broken sequences
    task automatic random_traffic(input int n_items);
        int               issued;
        int               pick;
        int               reps;
        logic [ACK_W-1:0] noise;
        issued = 0;
        while (issued < n_items) begin
            pick  = $urandom_range(0, 99);
            noise = 17'($urandom);
            if (pick < 3 || (flow_acked > flow_total && pick < 75)) begin
                send_event(CMD_START, noise);
                flow_acked = 0;
                issued++;
            end else if (flow_acked > flow_total) begin
                send_event(pick[0] ? CMD_ACK : CMD_TIMEOUT, noise);
                issued++;
            end else if (pick < 55) begin
                flow_acked = flow_acked + $urandom_range(1, 4);
                if (flow_acked > int'(ACK_MAX))
                    flow_acked = int'(ACK_MAX);
                send_event(CMD_ACK, 17'(flow_acked));
                issued++;
            end else if (pick < 75) begin
                // duplicate runs, often long enough for fast recovery
                reps = $urandom_range(1, 5);
                repeat (reps) begin
                    send_event(CMD_ACK, 17'(flow_acked));
                    issued++;
                end
            end else if (pick < 82) begin
                send_event(CMD_TIMEOUT, noise);
                issued++;
            end else if (pick < 85) begin
                send_event(CMD_UNUSED, noise);
                issued++;
            end else if (pick < 96) begin
                // step back a little: counts as a new ACK
                flow_acked = (flow_acked > 3) ? flow_acked - $urandom_range(1, 3)
                                              : flow_acked + 1;
                send_event(CMD_ACK, 17'(flow_acked));
                issued++;
            end else begin
                flow_acked = (noise > ACK_MAX) ? int'(ACK_MAX) : int'(noise);
                send_event(CMD_ACK, noise);
                issued++;
            end
        end
    endtask

    // Several register settings, extremes among them, one traffic phase each
    task automatic test_random_settings();
        for (int setting = 0; setting < 6; setting++) begin
            case (setting)
                0:       write_config(16'($urandom_range(1, 60)), 16'($urandom_range(2, 12)));
                1:       write_config(WIN_MAX, 16'd0);
                2:       write_config(16'd1, WIN_MAX);
                3:       write_config(16'($urandom), 16'($urandom));
                default: write_config(16'($urandom_range(20, 300)), 16'($urandom_range(0, 64)));
            endcase
            flow_acked = 0;
            send_event(CMD_START, 17'($urandom));
            random_traffic(145);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random_settings();
        settle();
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
src/tcprc_pkg.sv
src/tcprc_div.sv
src/tcprc_dp.sv
src/tcprc_ctrl.sv
src/tcp_reno_congestion_control_top.sv
verif/testbench.sv
